[rtl/core/slrrip_pkg.sv]
// Shared types and constants for the RRIP replacement core with signature insertion
// and stream bypass. It has no dependencies and is compiled first.
`default_nettype none

package slrrip_pkg;

    // Default geometry, handed to the top level as parameter defaults.
    localparam int SETS_DEF     = 2048;
    localparam int WAYS_DEF     = 16;
    localparam int SIG_BITS_DEF = 4;

    // Fixed field widths of the two channels.
    localparam int SET_IN_W = 11;
    localparam int WAY_IN_W = 4;
    localparam int ADDR_W   = 64;
    localparam int PC_W     = 8;
    localparam int VICT_W   = 4;
    localparam int RV_W     = 2;
    localparam int CNT_W    = 2;

    typedef logic [RV_W-1:0]   rv_t;
    typedef logic [CNT_W-1:0]  cnt_t;
    typedef logic [ADDR_W-1:0] addr_t;

    localparam rv_t   RV_MAX        = 2'd3;
    localparam rv_t   RV_MID        = 2'd1;
    localparam rv_t   RV_NEAR       = 2'd0;
    localparam cnt_t  CNT_MAX       = 2'd3;
    localparam cnt_t  CNT_RESET     = 2'd1;
    localparam cnt_t  STREAM_MAX    = 2'd3;
    localparam cnt_t  STREAM_THRESH = 2'd2;
    localparam addr_t STRIDE_LIMIT  = 64'd4096;

    // Request kinds.
    localparam logic KIND_FIND   = 1'b0;
    localparam logic KIND_UPDATE = 1'b1;

endpackage

`default_nettype wire

[rtl/core/slrrip_scan.sv]
// Shared scan unit: finds the first way at the maximum re-reference value in a
// packed set row and produces the aged row. Depends on slrrip_pkg.
`default_nettype none

module slrrip_scan
    import slrrip_pkg::*;
#(
    parameter int WAYS = WAYS_DEF
) (
    input  wire logic [RV_W*WAYS-1:0]     row,
    output logic                          found,
    output logic [$clog2(WAYS)-1:0]       first,
    output logic [RV_W*WAYS-1:0]          aged
);

    localparam int WAY_W = $clog2(WAYS);

    always_comb begin
        found = 1'b0;
        first = '0;
        aged  = row;
        // Walk downwards so that the lowest matching way wins.
        for (int w = WAYS - 1; w >= 0; w--) begin
            if (row[RV_W*w +: RV_W] == RV_MAX) begin
                found = 1'b1;
                first = WAY_W'(w);
            end else begin
                aged[RV_W*w +: RV_W] = row[RV_W*w +: RV_W] + rv_t'(1);
            end
        end
    end

endmodule

`default_nettype wire

[rtl/core/ship_lite_rrip_stream_bypass_core.sv]
// Replacement core: a find item gives its victim way, after ageing the set first when no
// way is at the maximum. An update is a bypass, a hit, a plain fill, or a fill that also
// trains down an evicted signature, and gives its result in each case. One item at a
// time, as the set memories are single-ported and the scan unit is shared; the next can
// be taken the cycle after the result is handed on.
// After reset a clearing pass over max(SETS, 2**SIG_BITS) entries runs with s_ready low.
`default_nettype none

module ship_lite_rrip_stream_bypass_core
    import slrrip_pkg::*;
#(
    parameter int SETS     = SETS_DEF,
    parameter int WAYS     = WAYS_DEF,
    parameter int SIG_BITS = SIG_BITS_DEF
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_valid,
    output logic                     s_ready,
    input  wire logic                s_kind,
    input  wire logic [SET_IN_W-1:0] s_set_index,
    input  wire logic [WAY_IN_W-1:0] s_way,
    input  wire logic [ADDR_W-1:0]   s_address,
    input  wire logic [PC_W-1:0]     s_pc_low,
    input  wire logic                s_hit,
    input  wire logic                s_victim_valid,
    output logic                     m_valid,
    input  wire logic                m_ready,
    output logic [VICT_W-1:0]        m_victim_way,
    output logic                     m_bypassed
);

    localparam int SET_W       = (SETS > 1) ? $clog2(SETS) : 1;
    localparam int WAY_W       = $clog2(WAYS);
    localparam int SIG_ENTRIES = 2 ** SIG_BITS;
    localparam int CLR_DEPTH   = (SETS > SIG_ENTRIES) ? SETS : SIG_ENTRIES;
    localparam int CLR_W       = $clog2(CLR_DEPTH);
    localparam int RROW_W      = RV_W * WAYS;
    localparam int SROW_W      = SIG_BITS * WAYS;
    localparam int STRM_W      = ADDR_W + CNT_W;
    localparam int WMOD_W      = WAY_IN_W + 2;

    // Set index reduction: multiply by a rounded-up reciprocal, exact for 11-bit inputs.
    localparam int DIV_SHIFT = 24;
    localparam int PROD_W    = DIV_SHIFT + 1 + SET_IN_W;
    localparam logic [DIV_SHIFT:0] SET_RECIP = (DIV_SHIFT+1)'((2 ** DIV_SHIFT) / SETS + 1);

    localparam logic [3:0] ST_CLEAR = 4'd0;
    localparam logic [3:0] ST_IDLE  = 4'd1;
    localparam logic [3:0] ST_DIV   = 4'd2;
    localparam logic [3:0] ST_ADDR  = 4'd3;
    localparam logic [3:0] ST_FIND1 = 4'd4;
    localparam logic [3:0] ST_FIND2 = 4'd5;
    localparam logic [3:0] ST_UPD   = 4'd6;
    localparam logic [3:0] ST_UHIT  = 4'd7;
    localparam logic [3:0] ST_UFILL = 4'd8;
    localparam logic [3:0] ST_UDEC  = 4'd9;
    localparam logic [3:0] ST_RESP  = 4'd10;

    // Memories: packed re-reference row, packed signature row and stream entry per
    // set, plus the reuse counter table.
    logic [RROW_W-1:0] rrv_mem   [SETS];
    logic [SROW_W-1:0] sig_mem   [SETS];
    logic [STRM_W-1:0] strm_mem  [SETS];
    cnt_t              reuse_mem [SIG_ENTRIES];

    logic [RROW_W-1:0]   rrv_rd_reg;
    logic [SROW_W-1:0]   sig_rd_reg;
    logic [STRM_W-1:0]   strm_rd_reg;
    cnt_t                reuse_rd_reg;

    logic                rrv_we, sig_we, strm_we, reuse_we;
    logic                set_re, reuse_re;
    logic [SET_W-1:0]    set_waddr, set_raddr;
    logic [SIG_BITS-1:0] reuse_waddr, reuse_raddr;
    logic [RROW_W-1:0]   rrv_wdata;
    logic [SROW_W-1:0]   sig_wdata;
    logic [STRM_W-1:0]   strm_wdata;
    cnt_t                reuse_wdata;

    logic [3:0]          state_reg, state_next;
    logic [CLR_W-1:0]    clr_reg, clr_next;
    logic                kind_reg, kind_next;
    logic [SET_IN_W-1:0] setin_reg, setin_next;
    logic [SET_IN_W-1:0] quo_reg, quo_next;
    logic [SET_W-1:0]    set_reg, set_next;
    logic [WAY_IN_W-1:0] way_reg, way_next;
    addr_t               addr_reg, addr_next;
    logic [PC_W-1:0]     pc_reg, pc_next;
    logic                hit_reg, hit_next;
    logic                vv_reg, vv_next;
    logic [RROW_W-1:0]   aged_reg, aged_next;
    logic [SIG_BITS-1:0] oldsig_reg, oldsig_next;
    rv_t                 oldrv_reg, oldrv_next;
    logic [WAY_W-1:0]    res_way_reg, res_way_next;
    logic                res_byp_reg, res_byp_next;
    logic                m_valid_reg, m_valid_next;
    logic [VICT_W-1:0]   m_way_reg, m_way_next;
    logic                m_byp_reg, m_byp_next;

    logic [PROD_W-1:0]   quo_prod;
    logic [SET_W-1:0]    set_mod;
    logic [WMOD_W-1:0]   way_mod;
    logic [WAY_W-1:0]    way_idx;
    logic [PC_W-1:0]     pc_mix;
    logic [SIG_BITS-1:0] sig;
    addr_t               prev_addr, stride;
    cnt_t                strm_cnt, strm_cnt_new;
    logic                strm_step;

    logic [RROW_W-1:0]   scan_row, scan_aged;
    logic                scan_found;
    logic [WAY_W-1:0]    scan_first;

    slrrip_scan #(
        .WAYS (WAYS)
    ) u_scan (
        .row   (scan_row),
        .found (scan_found),
        .first (scan_first),
        .aged  (scan_aged)
    );

    // The scan unit serves the first pass on the stored row and the second on the aged row.
    assign scan_row = (state_reg == ST_FIND2) ? aged_reg : rrv_rd_reg;

    assign quo_prod = PROD_W'(setin_reg) * PROD_W'(SET_RECIP);
    assign set_mod  = SET_W'(32'(setin_reg) - 32'(quo_reg) * 32'(SETS));
    assign pc_mix   = pc_reg ^ (pc_reg >> 4);
    assign sig      = SIG_BITS'({{SIG_BITS{1'b0}}, pc_mix});

    always_comb begin
        way_mod = WMOD_W'(way_reg);
        for (int i = 0; i < 8; i++) begin
            if (32'(way_mod) >= WAYS) begin
                way_mod = way_mod - WMOD_W'(WAYS);
            end
        end
        way_idx = WAY_W'(way_mod);
    end

    assign prev_addr = strm_rd_reg[STRM_W-1:CNT_W];
    assign strm_cnt  = strm_rd_reg[CNT_W-1:0];
    assign stride    = addr_reg - prev_addr;
    assign strm_step = (prev_addr != '0) && (stride != '0) && (stride < STRIDE_LIMIT);

    always_comb begin
        if (strm_step) begin
            strm_cnt_new = (strm_cnt == STREAM_MAX) ? strm_cnt : strm_cnt + cnt_t'(1);
        end else begin
            strm_cnt_new = (strm_cnt == '0) ? strm_cnt : strm_cnt - cnt_t'(1);
        end
    end

    always_comb begin
        state_next   = state_reg;
        clr_next     = clr_reg;
        kind_next    = kind_reg;
        setin_next   = setin_reg;
        quo_next     = quo_reg;
        set_next     = set_reg;
        way_next     = way_reg;
        addr_next    = addr_reg;
        pc_next      = pc_reg;
        hit_next     = hit_reg;
        vv_next      = vv_reg;
        aged_next    = aged_reg;
        oldsig_next  = oldsig_reg;
        oldrv_next   = oldrv_reg;
        res_way_next = res_way_reg;
        res_byp_next = res_byp_reg;
        m_valid_next = m_valid_reg & ~m_ready;
        m_way_next   = m_way_reg;
        m_byp_next   = m_byp_reg;

        rrv_we      = 1'b0;
        sig_we      = 1'b0;
        strm_we     = 1'b0;
        reuse_we    = 1'b0;
        set_re      = 1'b0;
        reuse_re    = 1'b0;
        set_waddr   = set_reg;
        set_raddr   = set_mod;
        reuse_waddr = sig;
        reuse_raddr = sig;
        rrv_wdata   = rrv_rd_reg;
        sig_wdata   = sig_rd_reg;
        strm_wdata  = {addr_reg, strm_cnt_new};
        reuse_wdata = reuse_rd_reg;

        case (state_reg)
            ST_CLEAR: begin
                set_waddr   = clr_reg[SET_W-1:0];
                reuse_waddr = clr_reg[SIG_BITS-1:0];
                rrv_we      = (32'(clr_reg) < SETS);
                sig_we      = rrv_we;
                strm_we     = rrv_we;
                reuse_we    = (32'(clr_reg) < SIG_ENTRIES);
                rrv_wdata   = '1;
                sig_wdata   = '0;
                strm_wdata  = '0;
                reuse_wdata = CNT_RESET;
                clr_next    = clr_reg + CLR_W'(1);
                if (clr_reg == CLR_W'(CLR_DEPTH - 1)) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_valid) begin
                    kind_next  = s_kind;
                    setin_next = s_set_index;
                    way_next   = s_way;
                    addr_next  = s_address;
                    pc_next    = s_pc_low;
                    hit_next   = s_hit;
                    vv_next    = s_victim_valid;
                    state_next = ST_DIV;
                end
            end
            ST_DIV: begin
                quo_next   = quo_prod[DIV_SHIFT +: SET_IN_W];
                state_next = ST_ADDR;
            end
            ST_ADDR: begin
                set_re     = 1'b1;
                set_next   = set_mod;
                state_next = (kind_reg == KIND_FIND) ? ST_FIND1 : ST_UPD;
            end
            ST_FIND1: begin
                if (scan_found) begin
                    res_way_next = scan_first;
                    res_byp_next = 1'b0;
                    state_next   = ST_RESP;
                end else begin
                    // No way at the maximum: age the whole set and look again.
                    rrv_we     = 1'b1;
                    rrv_wdata  = scan_aged;
                    aged_next  = scan_aged;
                    state_next = ST_FIND2;
                end
            end
            ST_FIND2: begin
                res_way_next = scan_found ? scan_first : '0;
                res_byp_next = 1'b0;
                state_next   = ST_RESP;
            end
            ST_UPD: begin
                strm_we      = 1'b1;
                res_way_next = '0;
                res_byp_next = 1'b0;
                if (strm_cnt_new >= STREAM_THRESH) begin
                    rrv_we                           = 1'b1;
                    rrv_wdata[RV_W*way_idx +: RV_W] = RV_MAX;
                    res_byp_next                     = 1'b1;
                    state_next                       = ST_RESP;
                end else if (hit_reg) begin
                    rrv_we                           = 1'b1;
                    rrv_wdata[RV_W*way_idx +: RV_W] = RV_NEAR;
                    reuse_re                         = 1'b1;
                    state_next                       = ST_UHIT;
                end else begin
                    // The evicted block's signature and value are kept before the fill.
                    oldsig_next                             = sig_rd_reg[SIG_BITS*way_idx +: SIG_BITS];
                    oldrv_next                              = rrv_rd_reg[RV_W*way_idx +: RV_W];
                    sig_we                                  = 1'b1;
                    sig_wdata[SIG_BITS*way_idx +: SIG_BITS] = sig;
                    reuse_re                                = 1'b1;
                    state_next                              = ST_UFILL;
                end
            end
            ST_UHIT: begin
                reuse_we    = 1'b1;
                reuse_wdata = (reuse_rd_reg == CNT_MAX) ? reuse_rd_reg
                                                        : reuse_rd_reg + cnt_t'(1);
                state_next  = ST_RESP;
            end
            ST_UFILL: begin
                rrv_we = 1'b1;
                if (reuse_rd_reg == CNT_MAX) begin
                    rrv_wdata[RV_W*way_idx +: RV_W] = RV_NEAR;
                end else if (reuse_rd_reg != '0) begin
                    rrv_wdata[RV_W*way_idx +: RV_W] = RV_MID;
                end else begin
                    rrv_wdata[RV_W*way_idx +: RV_W] = RV_MAX;
                end
                if (vv_reg && (oldrv_reg == RV_MAX)) begin
                    reuse_re    = 1'b1;
                    reuse_raddr = oldsig_reg;
                    state_next  = ST_UDEC;
                end else begin
                    state_next = ST_RESP;
                end
            end
            ST_UDEC: begin
                reuse_we    = 1'b1;
                reuse_waddr = oldsig_reg;
                reuse_wdata = (reuse_rd_reg == '0) ? reuse_rd_reg
                                                   : reuse_rd_reg - cnt_t'(1);
                state_next  = ST_RESP;
            end
            ST_RESP: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    m_way_next   = VICT_W'(res_way_reg);
                    m_byp_next   = res_byp_reg;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLEAR;
            clr_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            clr_reg     <= clr_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        kind_reg    <= kind_next;
        setin_reg   <= setin_next;
        quo_reg     <= quo_next;
        set_reg     <= set_next;
        way_reg     <= way_next;
        addr_reg    <= addr_next;
        pc_reg      <= pc_next;
        hit_reg     <= hit_next;
        vv_reg      <= vv_next;
        aged_reg    <= aged_next;
        oldsig_reg  <= oldsig_next;
        oldrv_reg   <= oldrv_next;
        res_way_reg <= res_way_next;
        res_byp_reg <= res_byp_next;
        m_way_reg   <= m_way_next;
        m_byp_reg   <= m_byp_next;
    end

    always_ff @(posedge aclk) begin
        if (rrv_we) begin
            rrv_mem[set_waddr] <= rrv_wdata;
        end
        if (set_re) begin
            rrv_rd_reg <= rrv_mem[set_raddr];
        end
    end

    always_ff @(posedge aclk) begin
        if (sig_we) begin
            sig_mem[set_waddr] <= sig_wdata;
        end
        if (set_re) begin
            sig_rd_reg <= sig_mem[set_raddr];
        end
    end

    always_ff @(posedge aclk) begin
        if (strm_we) begin
            strm_mem[set_waddr] <= strm_wdata;
        end
        if (set_re) begin
            strm_rd_reg <= strm_mem[set_raddr];
        end
    end

    always_ff @(posedge aclk) begin
        if (reuse_we) begin
            reuse_mem[reuse_waddr] <= reuse_wdata;
        end
        if (reuse_re) begin
            reuse_rd_reg <= reuse_mem[reuse_raddr];
        end
    end

    assign s_ready      = (state_reg == ST_IDLE);
    assign m_valid      = m_valid_reg;
    assign m_victim_way = m_way_reg;
    assign m_bypassed   = m_byp_reg;

endmodule

`default_nettype wire

[test/ship_lite_rrip_stream_bypass_core_tb.sv]
// Self-checking testbench for the RRIP replacement core with signature insertion and stream
// bypass: a directed table and random access sequences, results typed in for some rows and
// else from a behavioural predictor in this file. Depends on slrrip_pkg and the core only.
`default_nettype none

module ship_lite_rrip_stream_bypass_core_tb
    import slrrip_pkg::*;
();

    localparam int SETS        = SETS_DEF;
    localparam int WAYS        = WAYS_DEF;
    localparam int SIG_BITS    = SIG_BITS_DEF;
    localparam int SIG_ENTRIES = 1 << SIG_BITS;
    localparam int RANDOM_ITEMS = 1450;

    typedef struct packed {
        logic                kind;
        logic [SET_IN_W-1:0] set_index;
        logic [WAY_IN_W-1:0] way;
        addr_t               address;
        logic [PC_W-1:0]     pc_low;
        logic                hit;
        logic                victim_valid;
    } access_t;

    typedef struct packed {
        logic [VICT_W-1:0] victim_way;
        logic              bypassed;
    } verdict_t;

    logic                aclk           = 1'b0;
    logic                aresetn        = 1'b0;
    logic                s_valid        = 1'b0;
    logic                s_ready;
    logic                s_kind         = 1'b0;
    logic [SET_IN_W-1:0] s_set_index    = '0;
    logic [WAY_IN_W-1:0] s_way          = '0;
    logic [ADDR_W-1:0]   s_address      = '0;
    logic [PC_W-1:0]     s_pc_low       = '0;
    logic                s_hit          = 1'b0;
    logic                s_victim_valid = 1'b0;
    logic                m_valid;
    logic                m_ready        = 1'b0;
    logic [VICT_W-1:0]   m_victim_way;
    logic                m_bypassed;

    ship_lite_rrip_stream_bypass_core dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_kind         (s_kind),
        .s_set_index    (s_set_index),
        .s_way          (s_way),
        .s_address      (s_address),
        .s_pc_low       (s_pc_low),
        .s_hit          (s_hit),
        .s_victim_valid (s_victim_valid),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_victim_way   (m_victim_way),
        .m_bypassed     (m_bypassed)
    );

    always #6 aclk = ~aclk;

    // Predictor state, one copy of every table the core keeps.
    rv_t                 rrv_mem    [SETS*WAYS];
    logic [SIG_BITS-1:0] sig_mem    [SETS*WAYS];
    cnt_t                reuse_tbl  [SIG_ENTRIES];
    cnt_t                stride_cnt [SETS];
    addr_t               last_addr  [SETS];

    verdict_t pending_verdicts [$];
    int       errors       = 0;
    int       results_seen = 0;
    int       items_sent   = 0;
    int       burst_left   = 0;
    logic [VICT_W-1:0] recent_victim = '0;
    int       set_pool [8];

    task automatic clear_predictor();
        for (int i = 0; i < SETS*WAYS; i++) begin
            rrv_mem[i] = RV_MAX;
            sig_mem[i] = '0;
        end
        for (int i = 0; i < SIG_ENTRIES; i++) reuse_tbl[i] = CNT_RESET;
        for (int i = 0; i < SETS; i++) begin
            stride_cnt[i] = '0;
            last_addr[i]  = '0;
        end
    endtask

    // Applies one item to the predictor state and returns the result it should give.
    function automatic verdict_t replacement_outcome(access_t it);
        int                  s;
        int                  w;
        int                  base;
        int                  idx;
        int                  victim;
        bit                  found;
        logic [PC_W-1:0]     pc_mix;
        logic [SIG_BITS-1:0] sig;
        logic [SIG_BITS-1:0] old_sig;
        rv_t                 old_rv;
        cnt_t                cnt;
        addr_t               stride;
        verdict_t            v;

        v    = '0;
        s    = it.set_index % SETS;
        w    = it.way % WAYS;
        base = s * WAYS;

        if (it.kind == KIND_FIND) begin
            found  = 1'b0;
            victim = 0;
            for (int i = 0; i < WAYS; i++)
                if (!found && rrv_mem[base+i] == RV_MAX) begin
                    found  = 1'b1;
                    victim = i;
                end
            // No way at the distant value: age the whole set once and look again.
            if (!found) begin
                for (int i = 0; i < WAYS; i++)
                    if (rrv_mem[base+i] < RV_MAX) rrv_mem[base+i] = rrv_mem[base+i] + 1'b1;
                for (int i = 0; i < WAYS; i++)
                    if (!found && rrv_mem[base+i] == RV_MAX) begin
                        found  = 1'b1;
                        victim = i;
                    end
            end
            v.victim_way = victim[VICT_W-1:0];
            return v;
        end

        stride = it.address - last_addr[s];
        if (last_addr[s] != '0 && stride != '0 && stride < STRIDE_LIMIT) begin
            if (stride_cnt[s] < STREAM_MAX) stride_cnt[s] = stride_cnt[s] + 1'b1;
        end else if (stride_cnt[s] > '0) begin
            stride_cnt[s] = stride_cnt[s] - 1'b1;
        end
        last_addr[s] = it.address;

        idx    = base + w;
        pc_mix = it.pc_low ^ (it.pc_low >> 4);
        sig    = pc_mix[SIG_BITS-1:0];

        if (stride_cnt[s] >= STREAM_THRESH) begin
            rrv_mem[idx] = RV_MAX;
            v.bypassed   = 1'b1;
        end else if (it.hit) begin
            rrv_mem[idx] = RV_NEAR;
            if (reuse_tbl[sig] < CNT_MAX) reuse_tbl[sig] = reuse_tbl[sig] + 1'b1;
        end else begin
            // The evicted block's signature and value are taken before the fill.
            old_sig      = sig_mem[idx];
            old_rv       = rrv_mem[idx];
            sig_mem[idx] = sig;
            cnt          = reuse_tbl[sig];
            if (cnt == CNT_MAX)
                rrv_mem[idx] = RV_NEAR;
            else if (cnt >= CNT_MAX / 2)
                rrv_mem[idx] = RV_MID;
            else
                rrv_mem[idx] = RV_MAX;
            if (it.victim_valid && old_rv == RV_MAX && reuse_tbl[old_sig] > '0)
                reuse_tbl[old_sig] = reuse_tbl[old_sig] - 1'b1;
        end
        return v;
    endfunction

    function automatic access_t mk(logic kind, int set_i, int way_i, addr_t addr, int pc,
                                   bit hit, bit vv);
        access_t it;
        it.kind         = kind;
        it.set_index    = set_i[SET_IN_W-1:0];
        it.way          = way_i[WAY_IN_W-1:0];
        it.address      = addr;
        it.pc_low       = pc[PC_W-1:0];
        it.hit          = hit;
        it.victim_valid = vv;
        return it;
    endfunction

    function automatic addr_t far_addr();
        return {$urandom, $urandom};
    endfunction

    function automatic int pick_set();
        if ($urandom_range(0, 99) < 85) return set_pool[$urandom_range(0, 7)];
        return $urandom_range(0, SETS - 1);
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        errors++;
        $display("mismatch at result %0d: %s got %0d want %0d", results_seen, what, got,
                 want);
    endtask

    // Offers one item, with bursts and gaps, and records its result once it is accepted.
    task automatic send(input access_t it, input bit fixed, input verdict_t known);
        verdict_t v;
        if (burst_left == 0) begin
            if ($urandom_range(0, 3) != 0) begin
                s_valid <= 1'b0;
                repeat ($urandom_range(1, 10)) @(posedge aclk);
            end
            burst_left = $urandom_range(1, 30);
        end
        burst_left--;
        s_valid        <= 1'b1;
        s_kind         <= it.kind;
        s_set_index    <= it.set_index;
        s_way          <= it.way;
        s_address      <= it.address;
        s_pc_low       <= it.pc_low;
        s_hit          <= it.hit;
        s_victim_valid <= it.victim_valid;
        do @(posedge aclk); while (!s_ready);
        v = replacement_outcome(it);
        if (it.kind == KIND_FIND) recent_victim = v.victim_way;
        if (fixed) v = known;
        pending_verdicts.push_back(v);
        items_sent++;
    endtask

    // Result checker.
    always @(posedge aclk) begin
        verdict_t want;
        if (aresetn && m_valid && m_ready) begin
            results_seen++;
            if (pending_verdicts.size() == 0) begin
                report_mismatch("result with no item outstanding, victim_way", m_victim_way, -1);
            end else begin
                want = pending_verdicts.pop_front();
                if (m_victim_way !== want.victim_way)
                    report_mismatch("victim_way", m_victim_way, want.victim_way);
                if (m_bypassed !== want.bypassed)
                    report_mismatch("bypassed", m_bypassed, want.bypassed);
            end
        end
    end

    // Receiver: stall patterns that change every so often, plus one long hold-off.
    initial begin
        int mode;
        int left;
        int tick;
        bit held;
        mode = 0;
        left = 0;
        tick = 0;
        held = 1'b0;
        forever begin
            @(posedge aclk);
            tick++;
            if (!held && results_seen >= 400) begin
                held = 1'b1;
                m_ready <= 1'b0;
                repeat (300) @(posedge aclk);
            end else begin
                if (left == 0) begin
                    mode = $urandom_range(0, 3);
                    left = $urandom_range(20, 120);
                end
                left--;
                case (mode)
                    0: m_ready <= 1'b1;
                    1: m_ready <= 1'($urandom_range(0, 1));
                    2: m_ready <= ($urandom_range(0, 4) != 0);
                    default: m_ready <= (tick % 4 != 3);
                endcase
            end
        end
    end

    initial begin
        #(12 * 400000);
        $display("Simulation FAILED");
        $finish;
    end

    initial begin
        typedef struct {
            access_t  item;
            bit       fixed;
            verdict_t known;
        } table_row_t;
        table_row_t rows [$];
        int         r;
        int         s;
        int         len;
        addr_t      a;

        clear_predictor();
        set_pool[0] = 0;
        set_pool[1] = SETS - 1;
        for (int i = 2; i < 8; i++) set_pool[i] = $urandom_range(0, SETS - 1);

        // Directed table. Results are typed in where they follow from reset state or an
        // obvious stride; the other rows rely on the predictor.
        rows.push_back('{mk(KIND_FIND, 0, 0, 64'h0, 8'h00, 0, 0), 1, '{4'd0, 1'b0}});
        rows.push_back('{mk(KIND_FIND, 2047, 15, 64'h0, 8'h00, 0, 0), 1, '{4'd0, 1'b0}});
        rows.push_back('{mk(KIND_UPDATE, 0, 0, 64'h1000, 8'hFF, 0, 1), 1, '{4'd0, 1'b0}});
        rows.push_back('{mk(KIND_UPDATE, 0, 15, 64'h1040, 8'h00, 1, 0), 1, '{4'd0, 1'b0}});
        rows.push_back('{mk(KIND_UPDATE, 0, 3, 64'h1080, 8'hA5, 0, 1), 1, '{4'd0, 1'b1}});
        // Repeated address: zero stride counts down.
        rows.push_back('{mk(KIND_UPDATE, 0, 3, 64'h1080, 8'hA5, 0, 1), 0, '0});
        rows.push_back('{mk(KIND_FIND, 0, 0, 64'h0, 8'h00, 0, 0), 0, '0});
        rows.push_back('{mk(KIND_UPDATE, 1, 0, '1, 8'h11, 0, 0), 1, '{4'd0, 1'b0}});
        // Stride that wraps round the top of the address space.
        rows.push_back('{mk(KIND_UPDATE, 1, 1, 64'hFFE, 8'h11, 1, 0), 0, '0});
        // A stride of exactly the limit is not streaming.
        rows.push_back('{mk(KIND_UPDATE, 1, 2, 64'h1FFE, 8'h22, 0, 1), 0, '0});
        rows.push_back('{mk(KIND_UPDATE, 1, 2, 64'h2FFD, 8'h22, 0, 1), 0, '0});
        rows.push_back('{mk(KIND_UPDATE, 1, 2, 64'h2FFE, 8'h22, 0, 1), 1, '{4'd0, 1'b1}});
        rows.push_back('{mk(KIND_UPDATE, 1, 4, 64'h2FFF, 8'h44, 1, 1), 0, '0});
        rows.push_back('{mk(KIND_UPDATE, 1, 4, 64'h3000, 8'h44, 0, 0), 0, '0});
        rows.push_back('{mk(KIND_UPDATE, 1, 5, 64'h3001, 8'h55, 0, 1), 0, '0});
        rows.push_back('{mk(KIND_UPDATE, 1, 5, 64'h3001, 8'h55, 0, 1), 0, '0});
        rows.push_back('{mk(KIND_UPDATE, 1, 5, 64'h1000, 8'h55, 1, 0), 0, '0});
        rows.push_back('{mk(KIND_UPDATE, 2, 0, 64'h0, 8'h33, 1, 0), 0, '0});
        rows.push_back('{mk(KIND_UPDATE, 2, 1, 64'h40000, 8'h33, 1, 0), 0, '0});
        rows.push_back('{mk(KIND_UPDATE, 2, 2, 64'h80000, 8'h33, 1, 0), 0, '0});
        rows.push_back('{mk(KIND_UPDATE, 2, 7, 64'hC0000, 8'h00, 0, 1), 0, '0});
        rows.push_back('{mk(KIND_UPDATE, 3, 9, 64'h8000_0000_0000_0000, 8'h5A, 0, 1), 0, '0});
        rows.push_back('{mk(KIND_FIND, 2, 0, 64'h0, 8'h00, 0, 0), 0, '0});
        // A find ignores every field but the set.
        rows.push_back('{mk(KIND_FIND, 2047, 15, '1, 8'hFF, 1, 1), 1, '{4'd0, 1'b0}});

        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        for (int i = 0; i < rows.size(); i++) send(rows[i].item, rows[i].fixed, rows[i].known);

        while (items_sent < rows.size() + RANDOM_ITEMS) begin
            if (items_sent >= 700 && items_sent < 720) begin
                // Let the core drain completely before carrying on.
                s_valid <= 1'b0;
                burst_left = 0;
                while (pending_verdicts.size() != 0) @(posedge aclk);
                @(posedge aclk);
                items_sent = 720;
            end
            r = $urandom_range(0, 99);
            s = pick_set();
            if (r < 40) begin
                // Miss: find a victim, then fill it, usually into the way that was chosen.
                send(mk(KIND_FIND, s, $urandom_range(0, 15), far_addr(), $urandom_range(0, 255),
                        1'($urandom_range(0, 1)), 1'($urandom_range(0, 1))), 0, '0);
                send(mk(KIND_UPDATE, s,
                        ($urandom_range(0, 9) < 7) ? int'(recent_victim) : $urandom_range(0, 15),
                        far_addr(), $urandom_range(0, 255), 0, $urandom_range(0, 9) != 0),
                     0, '0);
            end else if (r < 60) begin
                send(mk(KIND_UPDATE, s, $urandom_range(0, 15), far_addr(),
                        $urandom_range(0, 255), 1, 1'($urandom_range(0, 1))), 0, '0);
            end else if (r < 75) begin
                // Streaming run with mostly short positive strides.
                a   = far_addr();
                len = $urandom_range(2, 8);
                for (int j = 0; j < len; j++) begin
                    case ($urandom_range(0, 9))
                        0:       a = a;
                        1:       a = a + 64'd4096 + 64'($urandom_range(0, 100000));
                        default: a = a + 64'($urandom_range(1, 4095));
                    endcase
                    send(mk(KIND_UPDATE, s, $urandom_range(0, 15), a, $urandom_range(0, 255),
                            $urandom_range(0, 2) == 0, 1'($urandom_range(0, 1))), 0, '0);
                end
            end else if (r < 85) begin
                // Touch every way so that finds have to age the set.
                for (int j = 0; j < WAYS; j++)
                    send(mk(KIND_UPDATE, s, j, far_addr(), $urandom_range(0, 255),
                            $urandom_range(0, 3) != 0, 1'($urandom_range(0, 1))), 0, '0);
                repeat (3)
                    send(mk(KIND_FIND, s, 0, 64'h0, 0, 0, 0), 0, '0);
            end else begin
                case ($urandom_range(0, 3))
                    0:       a = '0;
                    1:       a = '1;
                    2:       a = 64'($urandom_range(0, 8191));
                    default: a = far_addr();
                endcase
                send(mk(1'($urandom_range(0, 1)), $urandom_range(0, SETS - 1),
                        $urandom_range(0, 15), a, $urandom_range(0, 255),
                        1'($urandom_range(0, 1)), 1'($urandom_range(0, 1))),
                     0, '0);
            end
        end

        s_valid <= 1'b0;
        while (pending_verdicts.size() != 0) @(posedge aclk);
        repeat (16) @(posedge aclk);
        if (errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

`default_nettype wire
